>>> rtl/ltrm_pkg.sv
// Shared types, widths, codes and reset values for the link traffic rate meter.
`timescale 1ns / 1ps
`default_nettype none

package ltrm_pkg;

   localparam int unsigned OP_W      = 2;
   localparam int unsigned LEN_W     = 16;
   localparam int unsigned TIME_W    = 48;
   localparam int unsigned CNT_W     = 32;
   localparam int unsigned RATE_W    = 32;
   localparam int unsigned ALPHA_W   = 9;
   localparam int unsigned CSR_W     = 16;
   localparam int unsigned CSR_IDX_W = 2;

   // Item codes.
   localparam logic [OP_W-1:0] OP_RX   = 2'd0;
   localparam logic [OP_W-1:0] OP_TX   = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_WINDOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_FLOOR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EMA_ALPHA   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RX_LIMIT    = 2'd3;

   // Register reset values.
   localparam logic [CSR_W-1:0]   MIN_WINDOW_RST  = 16'd1000;
   localparam logic [CSR_W-1:0]   NOISE_FLOOR_RST = 16'd256;
   localparam logic [ALPHA_W-1:0] EMA_ALPHA_RST   = 9'd51;
   localparam logic [CSR_W-1:0]   RX_LIMIT_RST    = 16'd1600;

   // Unity weight in Q1.8.
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CHECK = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_SUM   = 4'b1000
   } state_type;

endpackage

`default_nettype wire

>>> rtl/ltrm_if.sv
// Valid/ready channel interfaces for the input items and the result items.
`timescale 1ns / 1ps
`default_nettype none

interface ltrm_req_if
   import ltrm_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [LEN_W-1:0]  frame_len;
   logic [TIME_W-1:0] now_ms;

   modport source (output valid, output op, output frame_len, output now_ms, input ready);
   modport sink   (input valid, input op, input frame_len, input now_ms, output ready);
endinterface

interface ltrm_rsp_if
   import ltrm_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [RATE_W-1:0] rx_rate_q8;
   logic [RATE_W-1:0] tx_rate_q8;

   modport source (output valid, output rx_rate_q8, output tx_rate_q8, input ready);
   modport sink   (input valid, input rx_rate_q8, input tx_rate_q8, output ready);
endinterface

`default_nettype wire

>>> rtl/ltrm_div.sv
// Bit-serial restoring divider lane: window bytes to a saturated, floored rate.
`timescale 1ns / 1ps
`default_nettype none

module ltrm_div
   import ltrm_pkg::*;
#(
   parameter int unsigned FRAC_BITS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [CNT_W-1:0]  bytes,
   input  wire logic [TIME_W-1:0] divisor,
   input  wire logic [CSR_W-1:0]  noise_floor,
   output logic                   done,
   output logic [RATE_W-1:0]      rate
);

   // Dividend is bytes * 8 with FRAC_BITS fraction bits appended.
   localparam int unsigned PAD_W = 3 + FRAC_BITS;
   localparam int unsigned DW    = CNT_W + PAD_W;
   localparam int unsigned CW    = $clog2(DW + 1);

   logic              busy_ff,  busy_in;
   logic              done_ff,  done_in;
   logic [CW-1:0]     cnt_ff,   cnt_in;
   logic [DW-1:0]     dvd_ff,   dvd_in;
   logic [TIME_W-1:0] dsr_ff,   dsr_in;
   logic [TIME_W-1:0] rem_ff,   rem_in;
   logic [RATE_W-1:0] quo_ff,   quo_in;
   logic              ovf_ff,   ovf_in;

   logic [TIME_W:0]   rem_sh;
   logic [TIME_W+1:0] diff;
   logic              ge;
   logic [RATE_W-1:0] raw;

   always_comb begin
      rem_sh = {rem_ff, dvd_ff[DW-1]};
      diff   = {1'b0, rem_sh} - {2'b00, dsr_ff};
      ge     = !diff[TIME_W+1];

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW);
         dvd_in  = {bytes, {PAD_W{1'b0}}};
         dsr_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         // One quotient bit per cycle; bits pushed past the top mean saturation.
         dvd_in = {dvd_ff[DW-2:0], 1'b0};
         rem_in = ge ? diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
         quo_in = {quo_ff[RATE_W-2:0], ge};
         ovf_in = ovf_ff | quo_ff[RATE_W-1];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   always_comb begin
      raw  = ovf_ff ? '1 : quo_ff;
      rate = (raw < {{(RATE_W-CSR_W){1'b0}}, noise_floor}) ? '0 : raw;
   end

   assign done = done_ff;

endmodule

`default_nettype wire

>>> rtl/ltrm_ema.sv
// Exponential smoothing lane: registered weighted products, then sum and scale.
`timescale 1ns / 1ps
`default_nettype none

module ltrm_ema
   import ltrm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               load,
   input  wire logic [RATE_W-1:0]  average,
   input  wire logic [RATE_W-1:0]  rate,
   input  wire logic [ALPHA_W-1:0] alpha,
   output logic [RATE_W-1:0]       smoothed
);

   localparam int unsigned PW = RATE_W + ALPHA_W;

   logic [ALPHA_W-1:0] alpha_sat;
   logic [PW-1:0]      p_old_ff, p_old_in;
   logic [PW-1:0]      p_new_ff, p_new_in;
   logic [PW:0]        sum;
   logic [PW-8:0]      scaled;

   always_comb begin
      alpha_sat = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
      p_old_in  = p_old_ff;
      p_new_in  = p_new_ff;
      if (load) begin
         p_old_in = PW'(average) * PW'(ALPHA_ONE - alpha_sat);
         p_new_in = PW'(rate) * PW'(alpha_sat);
      end
   end

   always_ff @(posedge clock) begin
      p_old_ff <= p_old_in;
      p_new_ff <= p_new_in;
   end

   always_comb begin
      sum      = {1'b0, p_old_ff} + {1'b0, p_new_ff};
      scaled   = sum[PW:8];
      smoothed = (|scaled[PW-8:RATE_W]) ? '1 : scaled[RATE_W-1:0];
   end

endmodule

`default_nettype wire

>>> rtl/link_traffic_rate_meter.sv
// Top level of the link traffic rate meter: counters, control and result register.
//
// Receive and transmit frame transfers are counted while the block stays idle, and the
// block is ready again on the next cycle. A tick transfer occupies the block while it
// checks the window, divides in the two bit-serial dividers that produce one quotient
// bit per cycle, registers the smoothing products and loads the result register,
// which waits as long as a previous result still waits there. A tick that only opens
// the window, falls short of the minimum window or sees time go backward returns to
// idle after the check cycle. Rates are kbps with RATE_FRAC_BITS fraction bits and
// saturate at all ones.
`timescale 1ns / 1ps
`default_nettype none

module link_traffic_rate_meter
   import ltrm_pkg::*;
#(
   parameter int unsigned RATE_FRAC_BITS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   ltrm_req_if.sink                  req_chan,
   ltrm_rsp_if.source                rsp_chan,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   state_type          state_ff, state_in;
   logic [CSR_W-1:0]   min_window_ff, min_window_in;
   logic [CSR_W-1:0]   noise_floor_ff, noise_floor_in;
   logic [ALPHA_W-1:0] alpha_ff, alpha_in;
   logic [CSR_W-1:0]   rx_limit_ff, rx_limit_in;
   logic [CNT_W-1:0]   rx_bytes_ff, rx_bytes_in;
   logic [CNT_W-1:0]   tx_bytes_ff, tx_bytes_in;
   logic [RATE_W-1:0]  rx_avg_ff, rx_avg_in;
   logic [RATE_W-1:0]  tx_avg_ff, tx_avg_in;
   logic [TIME_W-1:0]  start_ms_ff, start_ms_in;
   logic               started_ff, started_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               req_fire;
   logic               rsp_free;
   logic [CNT_W:0]     rx_sum, tx_sum;
   logic [TIME_W:0]    elapsed_full;
   logic [TIME_W-1:0]  elapsed;
   logic               too_early;
   logic               div_start;
   logic               ema_load;
   logic               rx_done, tx_done;
   logic [RATE_W-1:0]  rx_rate, tx_rate;
   logic [RATE_W-1:0]  rx_smooth, tx_smooth;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rx_sum       = {1'b0, rx_bytes_ff} + {{(CNT_W+1-LEN_W){1'b0}}, req_chan.frame_len};
      tx_sum       = {1'b0, tx_bytes_ff} + {{(CNT_W+1-LEN_W){1'b0}}, req_chan.frame_len};
      elapsed_full = {1'b0, now_ff} - {1'b0, start_ms_ff};
      elapsed      = elapsed_full[TIME_W-1:0];
      // Time going backward, a short window and zero elapsed time all skip the update.
      too_early    = elapsed_full[TIME_W]
                  || (elapsed < {{(TIME_W-CSR_W){1'b0}}, min_window_ff})
                  || (elapsed == '0);
      div_start    = (state_ff == ST_CHECK) && started_ff && !too_early;
      ema_load     = (state_ff == ST_DIV) && rx_done && tx_done;
   end

   always_comb begin
      state_in       = state_ff;
      min_window_in  = min_window_ff;
      noise_floor_in = noise_floor_ff;
      alpha_in       = alpha_ff;
      rx_limit_in    = rx_limit_ff;
      rx_bytes_in    = rx_bytes_ff;
      tx_bytes_in    = tx_bytes_ff;
      rx_avg_in      = rx_avg_ff;
      tx_avg_in      = tx_avg_ff;
      start_ms_in    = start_ms_ff;
      started_in     = started_ff;
      now_in         = now_ff;
      rsp_valid_in   = rsp_valid_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_WINDOW:  min_window_in  = csr_wdata;
            CSR_NOISE_FLOOR: noise_floor_in = csr_wdata;
            CSR_EMA_ALPHA:   alpha_in       = csr_wdata[ALPHA_W-1:0];
            CSR_RX_LIMIT:    rx_limit_in    = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.op == OP_RX) begin
                  if ((req_chan.frame_len != '0) && (req_chan.frame_len < rx_limit_ff)) begin
                     rx_bytes_in = rx_sum[CNT_W] ? '1 : rx_sum[CNT_W-1:0];
                  end
               end else if (req_chan.op == OP_TX) begin
                  if (req_chan.frame_len != '0) begin
                     tx_bytes_in = tx_sum[CNT_W] ? '1 : tx_sum[CNT_W-1:0];
                  end
               end else if (req_chan.op == OP_TICK) begin
                  now_in   = req_chan.now_ms;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (!started_ff) begin
               // The first tick only opens the window.
               started_in  = 1'b1;
               start_ms_in = now_ff;
               rx_bytes_in = '0;
               tx_bytes_in = '0;
               state_in    = ST_IDLE;
            end else if (too_early) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (ema_load) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (rsp_free) begin
               rx_avg_in    = rx_smooth;
               tx_avg_in    = tx_smooth;
               rx_bytes_in  = '0;
               tx_bytes_in  = '0;
               start_ms_in  = now_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         min_window_ff  <= MIN_WINDOW_RST;
         noise_floor_ff <= NOISE_FLOOR_RST;
         alpha_ff       <= EMA_ALPHA_RST;
         rx_limit_ff    <= RX_LIMIT_RST;
         rx_bytes_ff    <= '0;
         tx_bytes_ff    <= '0;
         rx_avg_ff      <= '0;
         tx_avg_ff      <= '0;
         start_ms_ff    <= '0;
         started_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         min_window_ff  <= min_window_in;
         noise_floor_ff <= noise_floor_in;
         alpha_ff       <= alpha_in;
         rx_limit_ff    <= rx_limit_in;
         rx_bytes_ff    <= rx_bytes_in;
         tx_bytes_ff    <= tx_bytes_in;
         rx_avg_ff      <= rx_avg_in;
         tx_avg_ff      <= tx_avg_in;
         start_ms_ff    <= start_ms_in;
         started_ff     <= started_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      now_ff <= now_in;
   end

   ltrm_div #(.FRAC_BITS(RATE_FRAC_BITS)) u_rx_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .bytes       (rx_bytes_ff),
      .divisor     (elapsed),
      .noise_floor (noise_floor_ff),
      .done        (rx_done),
      .rate        (rx_rate)
   );

   ltrm_div #(.FRAC_BITS(RATE_FRAC_BITS)) u_tx_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .bytes       (tx_bytes_ff),
      .divisor     (elapsed),
      .noise_floor (noise_floor_ff),
      .done        (tx_done),
      .rate        (tx_rate)
   );

   ltrm_ema u_rx_ema (
      .clock    (clock),
      .load     (ema_load),
      .average  (rx_avg_ff),
      .rate     (rx_rate),
      .alpha    (alpha_ff),
      .smoothed (rx_smooth)
   );

   ltrm_ema u_tx_ema (
      .clock    (clock),
      .load     (ema_load),
      .average  (tx_avg_ff),
      .rate     (tx_rate),
      .alpha    (alpha_ff),
      .smoothed (tx_smooth)
   );

   // The result register holds its values until the transfer completes.
   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.rx_rate_q8 = rx_avg_ff;
   assign rsp_chan.tx_rate_q8 = tx_avg_ff;

endmodule

`default_nettype wire

>>> rtl/ltrm_checker.sv
// Port-level assertions for the link traffic rate meter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ltrm_checker
   import ltrm_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic [OP_W-1:0]   req_op,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [RATE_W-1:0] rsp_rx,
   input wire logic [RATE_W-1:0] rsp_tx
);

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   // A result that waits keeps its values.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_rx) && $stable(rsp_tx)))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A frame transfer leaves the block ready on the next cycle and never produces a result.
   a_frame_ready: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_op != OP_TICK)) |=> (req_ready && !$rose(rsp_valid)))
      else $error("frame transfer stalled the block or made a result");

   // A tick always takes at least the check cycle.
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_op == OP_TICK)) |=> !req_ready)
      else $error("ready stayed high after a tick transfer");

endmodule

bind link_traffic_rate_meter ltrm_checker u_ltrm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_op    (req_chan.op),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_rx    (rsp_chan.rx_rate_q8),
   .rsp_tx    (rsp_chan.tx_rate_q8)
);

`default_nettype wire
